/* rtl/svg_pkg.sv */
// shared constants, payload types and controller/datapath interface types
package svg_pkg;

    // block geometry
    localparam int EDGE_BITS          = 2;
    localparam int MAX_SUPER_PER_AXIS = 16;
    localparam int MIDDLE_BLOCKS      = 256;
    localparam int DATA_BLOCKS        = 512;

    // fixed field widths
    localparam int COORD_W    = 8;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int MUSED_W    = 9;
    localparam int DUSED_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SB_CFG_W   = 5;

    // derived sizes
    localparam int SC_W        = COORD_W - 2 * EDGE_BITS;
    localparam int CUBE_BITS   = 3 * EDGE_BITS;
    localparam int TOP_DEPTH   = MAX_SUPER_PER_AXIS * MAX_SUPER_PER_AXIS * MAX_SUPER_PER_AXIS;
    localparam int TOP_AW      = $clog2(TOP_DEPTH);
    localparam int SB_W        = $clog2(MAX_SUPER_PER_AXIS + 1);
    localparam int MB_W        = $clog2(MIDDLE_BLOCKS);
    localparam int MCNT_W      = $clog2(MIDDLE_BLOCKS + 1);
    localparam int DB_W        = $clog2(DATA_BLOCKS);
    localparam int DCNT_W      = $clog2(DATA_BLOCKS + 1);
    localparam int MID_DEPTH   = MIDDLE_BLOCKS << CUBE_BITS;
    localparam int VOX_DEPTH   = DATA_BLOCKS << CUBE_BITS;
    localparam int TOP_ENTRY_W = MB_W + 1;
    localparam int MID_ENTRY_W = DB_W + 1;
    localparam int SWEEP_W     = (TOP_AW > CUBE_BITS) ? TOP_AW : CUBE_BITS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUPER_BLOCKS_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPER_BLOCKS_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUPER_BLOCKS_Z = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [MUSED_W-1:0]  middle_blocks_used;
        logic [DUSED_W-1:0]  data_blocks_used;
    } rsp_t;

    // configuration as seen by the datapath (counts already clamped)
    typedef struct packed {
        logic [VALUE_W-1:0] default_value;
        logic [SB_W-1:0]    nnx;
        logic [SB_W-1:0]    nny;
        logic [SB_W-1:0]    nnz;
    } cfg_t;

    typedef struct packed {
        logic                load_item;
        logic                latch_t1;
        logic                top_rd;
        logic                top_clr;
        logic                alloc_mid;
        logic                take_top;
        logic                mid_rd_top;
        logic                mid_fill;
        logic                alloc_data;
        logic                take_mid;
        logic                vox_rd_mid;
        logic                vox_fill;
        logic                vox_store;
        logic                sweep_clr;
        logic                sweep_inc;
        logic                res_load;
        logic                res_vox;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic out_of_range;
        logic is_write;
        logic eq_default;
        logic top_hit;
        logic mid_hit;
        logic mid_full;
        logic data_full;
        logic clr_last;
        logic fill_last;
        logic out_full;
    } stat_t;

endpackage

/* rtl/svg_ram.sv */
// generic single-port ram with registered read
module svg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/svg_dpath.sv */
// datapath: item register, index math, table memories, counters, result register
module svg_dpath import svg_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  req_t s_data,
    input  cfg_t cfg,
    input  cmd_t cmd,
    output stat_t stat,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    req_t                item_reg;
    logic [TOP_AW-1:0]   t1_reg;
    logic [TOP_AW-1:0]   top_i_reg;
    logic [MB_W-1:0]     mid_blk_reg;
    logic [DB_W-1:0]     data_blk_reg;
    logic [MCNT_W-1:0]   mid_cnt_reg;
    logic [DCNT_W-1:0]   data_cnt_reg;
    logic [SWEEP_W-1:0]  sweep_reg;
    logic                m_valid_reg;
    rsp_t                m_data_reg;

    logic [SC_W-1:0]        xs, ys, zs;
    logic [CUBE_BITS-1:0]   mid_part, vox_part;
    logic [TOP_AW-1:0]      top_i;
    logic [TOP_AW-1:0]      t1_next;

    logic                   top_we;
    logic [TOP_AW-1:0]      top_addr;
    logic [TOP_ENTRY_W-1:0] top_wdata, top_rdata;
    logic                   mid_we;
    logic [MB_W+CUBE_BITS-1:0] mid_addr;
    logic [MID_ENTRY_W-1:0] mid_wdata, mid_rdata;
    logic                   vox_we;
    logic [DB_W+CUBE_BITS-1:0] vox_addr;
    logic [VALUE_W-1:0]     vox_wdata, vox_rdata;

    // coordinate split: super block, middle part, voxel part
    assign xs = item_reg.coord_x[COORD_W-1:2*EDGE_BITS];
    assign ys = item_reg.coord_y[COORD_W-1:2*EDGE_BITS];
    assign zs = item_reg.coord_z[COORD_W-1:2*EDGE_BITS];
    assign mid_part = {item_reg.coord_z[2*EDGE_BITS-1:EDGE_BITS],
                       item_reg.coord_y[2*EDGE_BITS-1:EDGE_BITS],
                       item_reg.coord_x[2*EDGE_BITS-1:EDGE_BITS]};
    assign vox_part = {item_reg.coord_z[EDGE_BITS-1:0],
                       item_reg.coord_y[EDGE_BITS-1:0],
                       item_reg.coord_x[EDGE_BITS-1:0]};

    // top index in two multiply steps
    assign t1_next = TOP_AW'(ys) + TOP_AW'(cfg.nny) * TOP_AW'(zs);
    assign top_i   = TOP_AW'(xs) + TOP_AW'(cfg.nnx) * t1_reg;

    // top table port
    assign top_we    = cmd.top_clr | cmd.alloc_mid;
    assign top_wdata = cmd.top_clr ? '0 : {1'b1, mid_cnt_reg[MB_W-1:0]};
    always_comb begin
        if (cmd.top_clr) begin
            top_addr = sweep_reg[TOP_AW-1:0];
        end else if (cmd.top_rd) begin
            top_addr = top_i;
        end else begin
            top_addr = top_i_reg;
        end
    end

    // middle table port
    assign mid_we    = cmd.mid_fill | cmd.alloc_data;
    assign mid_wdata = cmd.mid_fill ? '0 : {1'b1, data_cnt_reg[DB_W-1:0]};
    always_comb begin
        if (cmd.mid_fill) begin
            mid_addr = {mid_blk_reg, sweep_reg[CUBE_BITS-1:0]};
        end else if (cmd.mid_rd_top) begin
            mid_addr = {top_rdata[MB_W-1:0], mid_part};
        end else begin
            mid_addr = {mid_blk_reg, mid_part};
        end
    end

    // voxel store port
    assign vox_we    = cmd.vox_fill | cmd.vox_store;
    assign vox_wdata = cmd.vox_fill ? cfg.default_value : item_reg.write_value;
    always_comb begin
        if (cmd.vox_fill) begin
            vox_addr = {data_blk_reg, sweep_reg[CUBE_BITS-1:0]};
        end else if (cmd.vox_rd_mid) begin
            vox_addr = {mid_rdata[DB_W-1:0], vox_part};
        end else begin
            vox_addr = {data_blk_reg, vox_part};
        end
    end

    svg_ram #(.WIDTH(TOP_ENTRY_W), .DEPTH(TOP_DEPTH)) u_top_ram (
        .aclk  (aclk),
        .we    (top_we),
        .addr  (top_addr),
        .wdata (top_wdata),
        .rdata (top_rdata)
    );

    svg_ram #(.WIDTH(MID_ENTRY_W), .DEPTH(MID_DEPTH)) u_mid_ram (
        .aclk  (aclk),
        .we    (mid_we),
        .addr  (mid_addr),
        .wdata (mid_wdata),
        .rdata (mid_rdata)
    );

    svg_ram #(.WIDTH(VALUE_W), .DEPTH(VOX_DEPTH)) u_vox_ram (
        .aclk  (aclk),
        .we    (vox_we),
        .addr  (vox_addr),
        .wdata (vox_wdata),
        .rdata (vox_rdata)
    );

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.latch_t1) begin
            t1_reg <= t1_next;
        end
        if (cmd.top_rd) begin
            top_i_reg <= top_i;
        end
        if (cmd.take_top) begin
            mid_blk_reg <= top_rdata[MB_W-1:0];
        end else if (cmd.alloc_mid) begin
            mid_blk_reg <= mid_cnt_reg[MB_W-1:0];
        end
        if (cmd.take_mid) begin
            data_blk_reg <= mid_rdata[DB_W-1:0];
        end else if (cmd.alloc_data) begin
            data_blk_reg <= data_cnt_reg[DB_W-1:0];
        end
        if (cmd.res_load) begin
            m_data_reg.read_value         <= item_reg.req_type ? '0 :
                                             (cmd.res_vox ? vox_rdata : cfg.default_value);
            m_data_reg.status             <= cmd.res_status;
            m_data_reg.middle_blocks_used <= MUSED_W'(mid_cnt_reg);
            m_data_reg.data_blocks_used   <= DUSED_W'(data_cnt_reg);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_cnt_reg  <= '0;
            data_cnt_reg <= '0;
            sweep_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.alloc_mid) begin
                mid_cnt_reg <= mid_cnt_reg + 1'b1;
            end
            if (cmd.alloc_data) begin
                data_cnt_reg <= data_cnt_reg + 1'b1;
            end
            if (cmd.sweep_clr) begin
                sweep_reg <= '0;
            end else if (cmd.sweep_inc) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_of_range = (SB_W'(xs) >= cfg.nnx) || (SB_W'(ys) >= cfg.nny) ||
                               (SB_W'(zs) >= cfg.nnz);
    assign stat.is_write     = item_reg.req_type;
    assign stat.eq_default   = item_reg.write_value == cfg.default_value;
    assign stat.top_hit      = top_rdata[TOP_ENTRY_W-1];
    assign stat.mid_hit      = mid_rdata[MID_ENTRY_W-1];
    assign stat.mid_full     = mid_cnt_reg == MCNT_W'(MIDDLE_BLOCKS);
    assign stat.data_full    = data_cnt_reg == DCNT_W'(DATA_BLOCKS);
    assign stat.clr_last     = sweep_reg == SWEEP_W'(TOP_DEPTH - 1);
    assign stat.fill_last    = &sweep_reg[CUBE_BITS-1:0];
    assign stat.out_full     = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/svg_ctrl.sv */
// controller: sequences table walks, allocation sweeps and result hand-off
module svg_ctrl import svg_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DEC     = 4'd2;
    localparam logic [3:0] ST_TOPRD   = 4'd3;
    localparam logic [3:0] ST_TOP     = 4'd4;
    localparam logic [3:0] ST_MID     = 4'd5;
    localparam logic [3:0] ST_FILLMID = 4'd6;
    localparam logic [3:0] ST_LINK    = 4'd7;
    localparam logic [3:0] ST_FILLVOX = 4'd8;
    localparam logic [3:0] ST_STORE   = 4'd9;
    localparam logic [3:0] ST_VOX     = 4'd10;
    localparam logic [3:0] ST_RES     = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                res_vox_reg, res_vox_next;

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        res_st_next  = res_st_reg;
        res_vox_next = res_vox_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.top_clr   = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.clr_last) begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.latch_t1 = 1'b1;
                res_vox_next = 1'b0;
                if (stat.out_of_range) begin
                    res_st_next = STAT_RANGE;
                    state_next  = ST_RES;
                end else if (stat.is_write && stat.eq_default) begin
                    res_st_next = STAT_IGNORED;
                    state_next  = ST_RES;
                end else begin
                    state_next = ST_TOPRD;
                end
            end
            ST_TOPRD: begin
                cmd.top_rd = 1'b1;
                state_next = ST_TOP;
            end
            ST_TOP: begin
                if (stat.top_hit) begin
                    cmd.take_top   = 1'b1;
                    cmd.mid_rd_top = 1'b1;
                    state_next     = ST_MID;
                end else if (!stat.is_write) begin
                    res_st_next = STAT_OK;
                    state_next  = ST_RES;
                end else if (stat.mid_full || stat.data_full) begin
                    res_st_next = STAT_FULL;
                    state_next  = ST_RES;
                end else begin
                    cmd.alloc_mid = 1'b1;
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_FILLMID;
                end
            end
            ST_MID: begin
                if (stat.mid_hit) begin
                    cmd.take_mid = 1'b1;
                    if (stat.is_write) begin
                        state_next = ST_STORE;
                    end else begin
                        cmd.vox_rd_mid = 1'b1;
                        state_next     = ST_VOX;
                    end
                end else if (!stat.is_write) begin
                    res_st_next = STAT_OK;
                    state_next  = ST_RES;
                end else if (stat.data_full) begin
                    res_st_next = STAT_FULL;
                    state_next  = ST_RES;
                end else begin
                    state_next = ST_LINK;
                end
            end
            ST_FILLMID: begin
                cmd.mid_fill  = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK: begin
                cmd.alloc_data = 1'b1;
                cmd.sweep_clr  = 1'b1;
                state_next     = ST_FILLVOX;
            end
            ST_FILLVOX: begin
                cmd.vox_fill  = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.vox_store = 1'b1;
                res_st_next   = STAT_OK;
                res_vox_next  = 1'b0;
                state_next    = ST_RES;
            end
            ST_VOX: begin
                res_st_next  = STAT_OK;
                res_vox_next = 1'b1;
                state_next   = ST_RES;
            end
            ST_RES: begin
                cmd.res_status = res_st_reg;
                cmd.res_vox    = res_vox_reg;
                if (!stat.out_full) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_st_reg  <= res_st_next;
        res_vox_reg <= res_vox_next;
    end

endmodule

/* rtl/sparse_voxel_grid_store.sv */
// top level: sparse voxel grid store with configuration registers
//
// Sparse 3-D voxel store: a top table with one entry per super block (16x16x16
// voxels), a pool of middle blocks (4x4x4 entries, one per data block) and a
// pool of data blocks (4x4x4 voxels), all in single-port rams with registered
// read. Each input beat is a read or a write at voxel coordinates; each one
// gives exactly one result beat carrying the value, a status code and the two
// pool fill counts. After reset the block sweeps the 4096-entry top table to
// empty, one entry a cycle, and takes no input beat until the sweep ends;
// configuration writes are taken at any time. Items are handled one at a time.
// From acceptance a read that reaches the voxel store or a write into an
// existing data block walks the decode, top read, top, middle and voxel or
// store states to the result load; reads of empty levels, out-of-range
// coordinates or ignored writes reach the load sooner. The load waits while
// the output register is full; the next beat is taken in the cycle after the
// load at the earliest. A write that allocates a data block first passes the
// link state and a 64-entry fill of the voxel block; one that also allocates
// a middle block fills its 64 entries in place of the middle table read. A new
// item is taken while the previous result beat waits in the output register.
module sparse_voxel_grid_store import svg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsp_t                  m_data,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [VALUE_W-1:0] default_reg;
    logic [SB_W-1:0]    nnx_reg, nny_reg, nnz_reg;
    logic [SB_W-1:0]    sb_clamped;
    logic [SB_CFG_W-1:0] sb_raw;
    cfg_t               cfg;
    cmd_t               cmd;
    stat_t              stat;

    // super block counts are stored already clamped to 1..max
    assign sb_raw = cfg_wdata[SB_CFG_W-1:0];
    always_comb begin
        if (sb_raw == '0) begin
            sb_clamped = SB_W'(1);
        end else if (int'(sb_raw) > MAX_SUPER_PER_AXIS) begin
            sb_clamped = SB_W'(MAX_SUPER_PER_AXIS);
        end else begin
            sb_clamped = SB_W'(sb_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_reg <= '0;
            nnx_reg     <= SB_W'(MAX_SUPER_PER_AXIS);
            nny_reg     <= SB_W'(MAX_SUPER_PER_AXIS);
            nnz_reg     <= SB_W'(MAX_SUPER_PER_AXIS);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEFAULT_VALUE:  default_reg <= cfg_wdata[VALUE_W-1:0];
                REG_SUPER_BLOCKS_X: nnx_reg     <= sb_clamped;
                REG_SUPER_BLOCKS_Y: nny_reg     <= sb_clamped;
                REG_SUPER_BLOCKS_Z: nnz_reg     <= sb_clamped;
                default: begin
                end
            endcase
        end
    end

    assign cfg.default_value = default_reg;
    assign cfg.nnx           = nnx_reg;
    assign cfg.nny           = nny_reg;
    assign cfg.nnz           = nnz_reg;

    // sequencing
    svg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // tables, counters and the result register
    svg_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
